[design/mm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and microcode ROM for the matrix multiplier.
package mm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int ACC_W       = 35;
	localparam int IDX_W       = 3;
	localparam int DIM_W       = 4;
	localparam int PC_W        = 3;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	localparam logic [1:0] REG_LEFT_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [1:0] REG_RIGHT_COLS = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_LEFT  = 2'd0,
		CMD_LOAD_RIGHT = 2'd1,
		CMD_COMPUTE    = 2'd2,
		CMD_NONE       = 2'd3
	} command_t;

	typedef struct packed {
		command_t           command;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic signed [ELEM_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] product_value;
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic                    last;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] rows_last;
		logic [IDX_W-1:0] inner_last;
		logic [IDX_W-1:0] cols_last;
	} dims_t;

	typedef struct packed {
		logic             valid;
		logic             first;
		logic             k_end;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NOT_GO,
		COND_K_MORE,
		COND_J_MORE,
		COND_I_MORE
	} cond_t;

	typedef struct packed {
		logic            clr_i;
		logic            clr_j;
		logic            clr_k;
		logic            inc_i;
		logic            inc_j;
		logic            inc_k;
		logic            issue;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
	localparam logic [PC_W-1:0] PC_INNER = 3'd1;
	localparam logic [PC_W-1:0] PC_COL   = 3'd2;
	localparam logic [PC_W-1:0] PC_ROW   = 3'd3;
	localparam logic [PC_W-1:0] PC_DONE  = 3'd4;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '0;
		w.cond = COND_ALWAYS;
		w.target = PC_IDLE;
		unique case (pc)
			PC_IDLE: begin
				w.clr_i = 1'b1;
				w.clr_j = 1'b1;
				w.clr_k = 1'b1;
				w.cond = COND_NOT_GO;
				w.target = PC_IDLE;
			end
			PC_INNER: begin
				w.issue = 1'b1;
				w.inc_k = 1'b1;
				w.cond = COND_K_MORE;
				w.target = PC_INNER;
			end
			PC_COL: begin
				w.clr_k = 1'b1;
				w.inc_j = 1'b1;
				w.cond = COND_J_MORE;
				w.target = PC_INNER;
			end
			PC_ROW: begin
				w.clr_j = 1'b1;
				w.inc_i = 1'b1;
				w.cond = COND_I_MORE;
				w.target = PC_INNER;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[design/mm_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/mm_seq.sv]
`timescale 1ns / 1ps
// Microcoded sequencer: step counter, loop counters and conditional jumps.
module mm_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  mm_pkg::dims_t                dims,
	output logic                         busy,
	output logic [mm_pkg::IDX_W-1:0]     i_idx,
	output logic [mm_pkg::IDX_W-1:0]     j_idx,
	output logic [mm_pkg::IDX_W-1:0]     k_idx,
	output mm_pkg::tag_t                 tag
);

	logic [mm_pkg::PC_W-1:0]  pc_q;
	logic [mm_pkg::PC_W-1:0]  pc_next;
	logic [mm_pkg::IDX_W-1:0] i_q;
	logic [mm_pkg::IDX_W-1:0] j_q;
	logic [mm_pkg::IDX_W-1:0] k_q;
	mm_pkg::ucode_t           uc;
	logic                     take;

	assign uc = mm_pkg::ucode_rom(pc_q);

	always_comb begin
		unique case (uc.cond)
			mm_pkg::COND_NEVER:  take = 1'b0;
			mm_pkg::COND_ALWAYS: take = 1'b1;
			mm_pkg::COND_NOT_GO: take = !go;
			mm_pkg::COND_K_MORE: take = (k_q != dims.inner_last);
			mm_pkg::COND_J_MORE: take = (j_q != dims.cols_last);
			mm_pkg::COND_I_MORE: take = (i_q != dims.rows_last);
			default:             take = 1'b1;
		endcase
		pc_next = take ? uc.target : pc_q + mm_pkg::PC_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mm_pkg::PC_IDLE;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			pc_q <= pc_next;
			if (uc.clr_i) begin
				i_q <= '0;
			end else if (uc.inc_i) begin
				i_q <= i_q + mm_pkg::IDX_W'(1);
			end
			if (uc.clr_j) begin
				j_q <= '0;
			end else if (uc.inc_j) begin
				j_q <= j_q + mm_pkg::IDX_W'(1);
			end
			if (uc.clr_k) begin
				k_q <= '0;
			end else if (uc.inc_k) begin
				k_q <= k_q + mm_pkg::IDX_W'(1);
			end
		end
	end

	assign busy = (pc_q != mm_pkg::PC_IDLE);
	assign i_idx = i_q;
	assign j_idx = j_q;
	assign k_idx = k_q;

	always_comb begin
		tag.valid = uc.issue;
		tag.first = (k_q == '0);
		tag.k_end = (k_q == dims.inner_last);
		tag.last = (i_q == dims.rows_last) && (j_q == dims.cols_last);
		tag.row = i_q;
		tag.col = j_q;
	end

endmodule

[design/mm_mac.sv]
`timescale 1ns / 1ps
// Multiply-accumulate pipeline and result register.
module mm_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mm_pkg::tag_t              tag,
	input  logic [mm_pkg::ELEM_W-1:0] left_data,
	input  logic [mm_pkg::ELEM_W-1:0] right_data,
	output logic                      result_valid,
	output mm_pkg::result_t           result
);

	mm_pkg::tag_t                    tag_s1;
	mm_pkg::tag_t                    tag_s2;
	logic signed [mm_pkg::PROD_W-1:0] product_s2;
	logic signed [mm_pkg::ACC_W-1:0]  acc_q;
	logic signed [mm_pkg::ACC_W-1:0]  acc_base;
	logic signed [mm_pkg::ACC_W-1:0]  acc_next;
	logic                             valid_q;
	mm_pkg::result_t                  result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		product_s2 <= $signed(left_data) * $signed(right_data);
	end

	always_comb begin
		acc_base = tag_s2.first ? '0 : acc_q;
		acc_next = acc_base + mm_pkg::ACC_W'(product_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (tag_s2.valid) begin
				acc_q <= acc_next;
			end
			valid_q <= tag_s2.valid && tag_s2.k_end;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid && tag_s2.k_end) begin
			result_q.product_value <= acc_next;
			result_q.out_row <= tag_s2.row;
			result_q.out_col <= tag_s2.col;
			result_q.last <= tag_s2.last;
		end
	end

	assign result_valid = valid_q;
	assign result = result_q;

endmodule

[design/matrix_multiply.sv]
`timescale 1ns / 1ps
// Top level: register port, element stores, sequencer and MAC pipeline.
// Load command: busy stays low, a new command may follow at once.
// Compute: one MAC per cycle through the shared multiplier while the inner loop runs
// (the column and row steps issue none); one result per output element, with a longer
// gap between rows; the last one in the final busy cycle.
// Results are one-cycle strobes; the receiver cannot stall them.
// Reset: dimension registers return to MAX_DIM each (8x8x8 by default); stores stay undefined until loaded.
module matrix_multiply #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mm_pkg::APB_AW-1:0] paddr,
	input  logic [mm_pkg::APB_DW-1:0] pwdata,
	output logic [mm_pkg::APB_DW-1:0] prdata,
	output logic                      pready,
	input  logic                      start,
	input  mm_pkg::item_t             item,
	output logic                      busy,
	output logic                      result_valid,
	output mm_pkg::result_t           result
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [mm_pkg::DIM_W-1:0] DIM_MAX = mm_pkg::DIM_W'(MAX_DIM);
	localparam logic [mm_pkg::IDX_W-1:0] IDX_MAX = mm_pkg::IDX_W'(MAX_DIM - 1);

	logic [mm_pkg::DIM_W-1:0] left_rows_q;
	logic [mm_pkg::DIM_W-1:0] inner_size_q;
	logic [mm_pkg::DIM_W-1:0] right_cols_q;
	logic                     cfg_wr;
	mm_pkg::dims_t            dims;
	logic                     accept;
	logic                     go;
	logic                     in_range;
	logic                     we_left;
	logic                     we_right;
	logic [AW-1:0]            waddr;
	logic [AW-1:0]            raddr_left;
	logic [AW-1:0]            raddr_right;
	logic [mm_pkg::ELEM_W-1:0] left_data;
	logic [mm_pkg::ELEM_W-1:0] right_data;
	logic [mm_pkg::IDX_W-1:0] i_idx;
	logic [mm_pkg::IDX_W-1:0] j_idx;
	logic [mm_pkg::IDX_W-1:0] k_idx;
	mm_pkg::tag_t             tag;

	function automatic logic [mm_pkg::IDX_W-1:0] dim_last(input logic [mm_pkg::DIM_W-1:0] d);
		logic [mm_pkg::IDX_W-1:0] r;
		if (d == '0) begin
			r = '0;
		end else if (d > DIM_MAX) begin
			r = IDX_MAX;
		end else begin
			r = mm_pkg::IDX_W'(d - mm_pkg::DIM_W'(1));
		end
		return r;
	endfunction

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q <= DIM_MAX;
			inner_size_q <= DIM_MAX;
			right_cols_q <= DIM_MAX;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mm_pkg::REG_LEFT_ROWS:  left_rows_q <= pwdata[mm_pkg::DIM_W-1:0];
				mm_pkg::REG_INNER_SIZE: inner_size_q <= pwdata[mm_pkg::DIM_W-1:0];
				mm_pkg::REG_RIGHT_COLS: right_cols_q <= pwdata[mm_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mm_pkg::REG_LEFT_ROWS:  prdata = mm_pkg::APB_DW'(left_rows_q);
			mm_pkg::REG_INNER_SIZE: prdata = mm_pkg::APB_DW'(inner_size_q);
			mm_pkg::REG_RIGHT_COLS: prdata = mm_pkg::APB_DW'(right_cols_q);
			default:                prdata = '0;
		endcase
	end

	always_comb begin
		dims.rows_last = dim_last(left_rows_q);
		dims.inner_last = dim_last(inner_size_q);
		dims.cols_last = dim_last(right_cols_q);
	end

	assign accept = start && !busy;
	assign go = start && (item.command == mm_pkg::CMD_COMPUTE);
	assign in_range = ({1'b0, item.row} < DIM_MAX) && ({1'b0, item.col} < DIM_MAX);
	assign we_left = accept && in_range && (item.command == mm_pkg::CMD_LOAD_LEFT);
	assign we_right = accept && in_range && (item.command == mm_pkg::CMD_LOAD_RIGHT);
	assign waddr = AW'(item.row * MAX_DIM + item.col);
	assign raddr_left = AW'(i_idx * MAX_DIM + k_idx);
	assign raddr_right = AW'(k_idx * MAX_DIM + j_idx);

	mm_ram #(
		.WIDTH(mm_pkg::ELEM_W),
		.DEPTH(DEPTH)
	) u_left_store (
		.clk(clk),
		.we(we_left),
		.waddr(waddr),
		.wdata(item.value),
		.raddr(raddr_left),
		.rdata(left_data)
	);

	mm_ram #(
		.WIDTH(mm_pkg::ELEM_W),
		.DEPTH(DEPTH)
	) u_right_store (
		.clk(clk),
		.we(we_right),
		.waddr(waddr),
		.wdata(item.value),
		.raddr(raddr_right),
		.rdata(right_data)
	);

	mm_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.dims(dims),
		.busy(busy),
		.i_idx(i_idx),
		.j_idx(j_idx),
		.k_idx(k_idx),
		.tag(tag)
	);

	mm_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.tag(tag),
		.left_data(left_data),
		.right_data(right_data),
		.result_valid(result_valid),
		.result(result)
	);

	a_result_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat outside a compute");

	a_last_isolated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result beat right after the last beat");

	a_busy_from_compute: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && item.command == mm_pkg::CMD_COMPUTE))
		else $error("busy rose without a compute command");

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(we_left || we_right))
		else $error("store written during compute");

endmodule

[sim/matrix_multiply_checker.sv]
`timescale 1ns / 1ps
// Checker for the matrix multiplier: tracks config and operand beats, predicts and compares products.
module matrix_multiply_checker
	import mm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              start,
	input  logic              busy,
	input  item_t             item,
	input  logic              result_valid,
	input  result_t           result,
	output int                errors,
	output int                pending
);

	logic signed [ELEM_W-1:0] left_mem [MAX_DIM_DEF*MAX_DIM_DEF];
	logic signed [ELEM_W-1:0] right_mem [MAX_DIM_DEF*MAX_DIM_DEF];
	logic [DIM_W-1:0] rows_cfg, inner_cfg, cols_cfg;
	result_t product_q [$];

	function automatic int dim_used(input logic [DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return int'(d);
	endfunction

	task automatic predict_product();
		int nr, nk, nc;
		longint sum;
		result_t r;
		nr = dim_used(rows_cfg);
		nk = dim_used(inner_cfg);
		nc = dim_used(cols_cfg);
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				sum = 0;
				for (int k = 0; k < nk; k++)
					sum += longint'(left_mem[i*MAX_DIM_DEF+k]) *
						longint'(right_mem[k*MAX_DIM_DEF+j]);
				r.product_value = sum[ACC_W-1:0];
				r.out_row = IDX_W'(i);
				r.out_col = IDX_W'(j);
				r.last = (i == nr - 1) && (j == nc - 1);
				product_q.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			rows_cfg = DIM_W'(MAX_DIM_DEF);
			inner_cfg = DIM_W'(MAX_DIM_DEF);
			cols_cfg = DIM_W'(MAX_DIM_DEF);
			product_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_LEFT_ROWS:  rows_cfg = pwdata[DIM_W-1:0];
					REG_INNER_SIZE: inner_cfg = pwdata[DIM_W-1:0];
					REG_RIGHT_COLS: cols_cfg = pwdata[DIM_W-1:0];
					default: ;
				endcase
			end
			if (result_valid) begin
				if (product_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result value %0d row %0d col %0d last %0b",
							$time, result.product_value, result.out_row, result.out_col,
							result.last);
					errors++;
				end else begin
					want = product_q.pop_front();
					if (result.product_value !== want.product_value ||
						result.out_row !== want.out_row || result.out_col !== want.out_col ||
						result.last !== want.last) begin
						if (errors < 10)
							$display("%0t: expected value %0d row %0d col %0d last %0b, got value %0d row %0d col %0d last %0b",
								$time, want.product_value, want.out_row, want.out_col,
								want.last, result.product_value, result.out_row,
								result.out_col, result.last);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				case (item.command)
					CMD_LOAD_LEFT:  left_mem[{item.row, item.col}] = item.value;
					CMD_LOAD_RIGHT: right_mem[{item.row, item.col}] = item.value;
					CMD_COMPUTE:    predict_product();
					default: ;
				endcase
			end
			pending = product_q.size();
		end
	end

endmodule

[sim/matrix_multiply_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the matrix multiplier: stimulus, register setup and verdict.
module matrix_multiply_tb;
	import mm_pkg::*;

	localparam int ITEM_TARGET = 320;
	localparam int CYCLE_LIMIT = 1000000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              start = 1'b0;
	item_t             item = '0;
	logic              busy;
	logic              result_valid;
	result_t           result;
	int                mismatches;
	int                outstanding;

	int                items_sent = 0;
	int                cycles = 0;
	bit                no_idle = 1'b0;
	bit [63:0]         left_written = '0;
	bit [63:0]         right_written = '0;
	int                rows_used, inner_used, cols_used;

	matrix_multiply dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.start(start), .item(item), .busy(busy),
		.result_valid(result_valid), .result(result)
	);

	matrix_multiply_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result),
		.errors(mismatches), .pending(outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int dim_in_use(input logic [DIM_W-1:0] d);
		if (d == 0)
			return 1;
		return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
	endfunction

	function automatic logic signed [ELEM_W-1:0] element_value();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '1;
			3: return '0;
			default: return ELEM_W'($urandom());
		endcase
	endfunction

	task automatic send_command(input command_t cmd, input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col, input logic signed [ELEM_W-1:0] value);
		item_t beat;
		int gap;
		beat.command = cmd;
		beat.row = row;
		beat.col = col;
		beat.value = value;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= beat;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (cmd != CMD_NONE)
			items_sent++;
		if (cmd == CMD_LOAD_LEFT)
			left_written[{row, col}] = 1'b1;
		if (cmd == CMD_LOAD_RIGHT)
			right_written[{row, col}] = 1'b1;
	endtask

	task automatic compute();
		send_command(CMD_COMPUTE, IDX_W'($urandom()), IDX_W'($urandom()), ELEM_W'($urandom()));
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
		logic [APB_DW-1:0] data;
		data = $urandom();
		data[DIM_W-1:0] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
		input logic [DIM_W-1:0] c);
		drain();
		write_reg(REG_LEFT_ROWS, r);
		write_reg(REG_INNER_SIZE, k);
		write_reg(REG_RIGHT_COLS, c);
		rows_used = dim_in_use(r);
		inner_used = dim_in_use(k);
		cols_used = dim_in_use(c);
	endtask

	task automatic fill_operands();
		for (int i = 0; i < rows_used; i++)
			for (int k = 0; k < inner_used; k++)
				if (!left_written[i*MAX_DIM_DEF+k])
					send_command(CMD_LOAD_LEFT, IDX_W'(i), IDX_W'(k), element_value());
		for (int k = 0; k < inner_used; k++)
			for (int j = 0; j < cols_used; j++)
				if (!right_written[k*MAX_DIM_DEF+j])
					send_command(CMD_LOAD_RIGHT, IDX_W'(k), IDX_W'(j), element_value());
	endtask

	task automatic stray_loads(input int n);
		int pick;
		command_t cmd;
		for (int s = 0; s < n; s++) begin
			pick = $urandom_range(0, 9);
			cmd = (pick == 0) ? CMD_NONE : (pick < 5) ? CMD_LOAD_LEFT : CMD_LOAD_RIGHT;
			send_command(cmd, IDX_W'($urandom()), IDX_W'($urandom()), element_value());
		end
	endtask

	function automatic logic [DIM_W-1:0] random_dim();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick < 10)
			return DIM_W'($urandom_range(1, 4));
		if (pick == 10)
			return '0;
		if (pick == 11)
			return '1;
		if (pick == 12)
			return DIM_W'(MAX_DIM_DEF);
		return DIM_W'($urandom_range(5, 15));
	endfunction

	initial begin : stimulus
		int phase;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_dims(4'd2, 4'd2, 4'd2);
		send_command(CMD_LOAD_LEFT, 3'd0, 3'd0, 16'sh8000);
		send_command(CMD_LOAD_LEFT, 3'd0, 3'd1, 16'sh8000);
		send_command(CMD_LOAD_LEFT, 3'd1, 3'd0, 16'sh7fff);
		send_command(CMD_LOAD_LEFT, 3'd1, 3'd1, 16'sh7fff);
		send_command(CMD_LOAD_RIGHT, 3'd0, 3'd0, 16'sh8000);
		send_command(CMD_LOAD_RIGHT, 3'd1, 3'd0, 16'sh8000);
		send_command(CMD_LOAD_RIGHT, 3'd0, 3'd1, 16'sh7fff);
		send_command(CMD_LOAD_RIGHT, 3'd1, 3'd1, 16'sh8000);
		send_command(CMD_NONE, 3'd7, 3'd7, 16'sh7fff);
		send_command(CMD_LOAD_LEFT, 3'd7, 3'd7, 16'sh7fff);
		send_command(CMD_LOAD_RIGHT, 3'd7, 3'd7, 16'sh8000);
		compute();
		compute();
		set_dims(4'd0, 4'd0, 4'd0);
		compute();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if (phase == 0)
				set_dims(4'd15, 4'd15, 4'd15);
			else if (phase == 1)
				set_dims(4'd8, 4'd8, 4'd8);
			else
				set_dims(random_dim(), random_dim(), random_dim());
			stray_loads($urandom_range(0, 6));
			fill_operands();
			compute();
			if ($urandom_range(0, 1)) begin
				stray_loads($urandom_range(0, 3));
				compute();
			end
			phase++;
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
